// ===== sv/gpr_pkg.sv =====
// shared types and constants of the gaussian pyramid reduce block
`timescale 1ns / 1ps
`default_nettype none
package gpr_pkg;

  // line store depth default
  localparam int MAX_WIDTH_DEF = 4096;

  // field widths
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int VSUM_W     = 10;
  localparam int HSUM_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SHIFT      = 4;

  // register reset values
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic                ROUND_RST  = 1'b1;

  // half of the divisor, added when rounding
  localparam logic [HSUM_W-1:0] ROUND_BIAS = 12'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ROUND  = 2'd2
  } cfg_idx_t;

  // per-pixel control handed from the scan stage to the kernel stage
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             odd_row;
    logic             top_is_mid;
    logic             first_col;
    logic             odd_col;
    logic             last_col;
    logic             last_row;
    logic             active;
    logic             round_en;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/gpr_ram.sv =====
// generic single-address ram with registered read, old data on a same-cycle write
`timescale 1ns / 1ps
`default_nettype none
module gpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             re,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[addr];
    end
    if (we) begin
      mem_r[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/gpr_scan.sv =====
// configuration registers, raster counters and line store addressing
`timescale 1ns / 1ps
`default_nettype none
module gpr_scan #(
  parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            accept,
  input  wire logic [gpr_pkg::PIX_W-1:0]       pixel,
  output logic [CW-1:0]                        addr,
  output logic                                 odd_we,
  output logic                                 even_we,
  output gpr_pkg::item_t                       item
);

  localparam int WW = (CW + 1 > gpr_pkg::WIDTH_W) ? CW + 1 : gpr_pkg::WIDTH_W;
  localparam logic [WW-1:0] MAX_X = WW'(MAX_WIDTH);

  logic [gpr_pkg::WIDTH_W-1:0]  width_r,  width_nxt;
  logic [gpr_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic                         round_r,  round_nxt;
  logic [CW-1:0]                col_r,    col_nxt;
  logic [gpr_pkg::HEIGHT_W-1:0] row_r,    row_nxt;

  logic [WW-1:0]                width_x;
  logic [WW-1:0]                wm1;
  logic [gpr_pkg::HEIGHT_W-1:0] hm1;
  logic                         last_col;
  logic                         last_row;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    round_nxt  = round_r;
    if (cfg_valid) begin
      unique case (gpr_pkg::cfg_idx_t'(cfg_index))
        gpr_pkg::CFG_WIDTH:  width_nxt  = cfg_data[gpr_pkg::WIDTH_W-1:0];
        gpr_pkg::CFG_HEIGHT: height_nxt = cfg_data[gpr_pkg::HEIGHT_W-1:0];
        gpr_pkg::CFG_ROUND:  round_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  // last column index: zero width counts as one, wide images saturate
  always_comb begin
    width_x = WW'(width_r);
    if (width_r == '0) begin
      wm1 = '0;
    end else if (width_x > MAX_X) begin
      wm1 = MAX_X - WW'(1);
    end else begin
      wm1 = width_x - WW'(1);
    end
    hm1 = (height_r == '0) ? '0 : height_r - 16'd1;
  end

  assign last_col = WW'(col_r) >= wm1;
  assign last_row = row_r >= hm1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gpr_pkg::WIDTH_RST;
      height_r <= gpr_pkg::HEIGHT_RST;
      round_r  <= gpr_pkg::ROUND_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      round_r  <= round_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // both stores read at the column, the store of this row parity is written
  assign addr    = col_r;
  assign odd_we  = accept && row_r[0];
  assign even_we = accept && !row_r[0];

  always_comb begin
    item.px         = pixel;
    item.odd_row    = row_r[0];
    item.top_is_mid = row_r[0] ? (row_r == 16'd1) : (row_r == '0);
    item.first_col  = (col_r == '0);
    item.odd_col    = col_r[0];
    item.last_col   = last_col;
    item.last_row   = last_row;
    item.active     = row_r[0] || last_row;
    item.round_en   = round_r;
  end

endmodule
`default_nettype wire

// ===== sv/gpr_kernel.sv =====
// vertical and horizontal binomial sums and the result register
`timescale 1ns / 1ps
`default_nettype none
module gpr_kernel (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire gpr_pkg::item_t             item,
  input  wire logic [gpr_pkg::PIX_W-1:0]  odd_rd,
  input  wire logic [gpr_pkg::PIX_W-1:0]  even_rd,
  output logic                            busy,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [gpr_pkg::PIX_W-1:0]       out_pixel,
  output logic                            out_row_end,
  output logic                            out_frame_end
);

  gpr_pkg::item_t               s1_item_r;
  logic                         s1_valid_r, s1_valid_nxt;
  logic [gpr_pkg::VSUM_W-1:0]   left_r,     left_nxt;
  logic [gpr_pkg::VSUM_W-1:0]   centre_r,   centre_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [gpr_pkg::PIX_W-1:0]    pixel_r;
  logic                         row_end_r;
  logic                         frame_end_r;

  logic [gpr_pkg::PIX_W-1:0]    top;
  logic [gpr_pkg::PIX_W-1:0]    mid;
  logic [gpr_pkg::VSUM_W-1:0]   vsum;
  logic [gpr_pkg::VSUM_W-1:0]   left_e;
  logic [gpr_pkg::VSUM_W-1:0]   centre_e;
  logic [gpr_pkg::HSUM_W-1:0]   hsum;
  logic                         emit;
  logic                         out_free;
  logic                         go;

  always_comb begin
    mid  = s1_item_r.odd_row ? even_rd : s1_item_r.px;
    top  = s1_item_r.top_is_mid ? mid : odd_rd;
    vsum = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, s1_item_r.px};
    // an even column refreshes the centre sum before it is used, the first column the left sum as well
    left_e   = (!s1_item_r.odd_col && s1_item_r.first_col) ? vsum : left_r;
    centre_e = !s1_item_r.odd_col ? vsum : centre_r;
    hsum = {2'b00, left_e} + {1'b0, centre_e, 1'b0} + {2'b00, vsum}
         + (s1_item_r.round_en ? gpr_pkg::ROUND_BIAS : '0);
  end

  assign emit     = s1_item_r.active && (s1_item_r.odd_col || s1_item_r.last_col);
  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && (!emit || out_free);
  assign busy     = s1_valid_r && !go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end

    left_nxt   = left_r;
    centre_nxt = centre_r;
    if (go && s1_item_r.active) begin
      left_nxt = s1_item_r.odd_col ? vsum : left_e;
      centre_nxt = centre_e;
    end

    out_valid_nxt = out_valid_r;
    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      left_r      <= '0;
      centre_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      left_r      <= left_nxt;
      centre_r    <= centre_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
    end
    if (go && emit) begin
      pixel_r     <= hsum[gpr_pkg::HSUM_W-1:gpr_pkg::SHIFT];
      row_end_r   <= s1_item_r.last_col;
      frame_end_r <= s1_item_r.last_col && s1_item_r.last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = pixel_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

endmodule
`default_nettype wire

// ===== sv/gaussian_reduce_3x3_downscale_unit.sv =====
// top level of the 3x3 gaussian pyramid reduce unit
`timescale 1ns / 1ps
`default_nettype none
// takes 8-bit gray pixels in raster order, one per clock, and gives the half-size
// image: each result is the [1 2 1] x [1 2 1] sum around an even row and even
// column, divided by 16 (plus 8 first when rounding is on), with edge pixels
// replicated at every border. a pixel is taken every cycle while the result side
// keeps up; a pixel reaches the result it completes through the registered read
// of the two line stores and then the result register. results appear on odd
// source rows (and on the last row), at odd columns (and at the last column),
// flagged with row-end and frame-end. the line stores hold no valid bits: only
// the first rows of a frame are read before they are written.
// write image_width, image_height and round_enable only while the unit is idle
module gaussian_reduce_3x3_downscale_unit #(
  parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel requests in
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [gpr_pkg::PIX_W-1:0]       in_pixel_in,
  // result requests out
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [gpr_pkg::PIX_W-1:0]            out_pixel_out,
  output logic                                 out_row_end,
  output logic                                 out_frame_end,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                        accept;
  logic [CW-1:0]               addr;
  logic                        odd_we;
  logic                        even_we;
  logic [gpr_pkg::PIX_W-1:0]   odd_rd;
  logic [gpr_pkg::PIX_W-1:0]   even_rd;
  logic                        busy;
  gpr_pkg::item_t              item;

  // a request is taken whenever the kernel stage can move on
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  gpr_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (in_pixel_in),
    .addr      (addr),
    .odd_we    (odd_we),
    .even_we   (even_we),
    .item      (item)
  );

  // reads return the old entry, so a row overwrites the one two rows above it
  gpr_ram #(
    .WIDTH (gpr_pkg::PIX_W),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_odd_store (
    .clk   (clk),
    .re    (accept),
    .we    (odd_we),
    .addr  (addr),
    .wdata (in_pixel_in),
    .rdata (odd_rd)
  );

  gpr_ram #(
    .WIDTH (gpr_pkg::PIX_W),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_even_store (
    .clk   (clk),
    .re    (accept),
    .we    (even_we),
    .addr  (addr),
    .wdata (in_pixel_in),
    .rdata (even_rd)
  );

  // read data is held by the stores while the kernel stage waits
  gpr_kernel u_kernel (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .item          (item),
    .odd_rd        (odd_rd),
    .even_rd       (even_rd),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire

// ===== sv/gpr_chk.sv =====
// port checker of the reduce unit and its bind
`timescale 1ns / 1ps
`default_nettype none
module gpr_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [gpr_pkg::PIX_W-1:0]  out_pixel_out,
  input wire logic                       out_row_end,
  input wire logic                       out_frame_end
);

  // no result is pending straight after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // the frame ends only on the end of a row
  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_out) && $stable(out_row_end)
      && $stable(out_frame_end))
    else $error("stalled result changed");

endmodule

bind gaussian_reduce_3x3_downscale_unit gpr_chk u_gpr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_out (out_pixel_out),
  .out_row_end   (out_row_end),
  .out_frame_end (out_frame_end)
);
`default_nettype wire
